// ===== design/bdgq_pkg.sv =====
// Shared types, codes and reset values for the button debounce and gesture qualifier.
package bdgq_pkg;

  localparam int unsigned NumButtons = 5;
  localparam int unsigned StableWidth = 9;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Button positions in the level vectors.
  localparam int unsigned IdxFwd = 0;
  localparam int unsigned IdxBwd = 1;
  localparam int unsigned IdxB1 = 2;
  localparam int unsigned IdxB2 = 3;
  localparam int unsigned IdxB3 = 4;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] RegDebounce = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegPairingHold = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegTapWindow = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegLongPress = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegMultipress = 3'd4;

  // Configuration reset values.
  localparam logic [7:0] DebounceReset = 8'd50;
  localparam logic [15:0] PairingHoldReset = 16'd15000;
  localparam logic [15:0] TapWindowReset = 16'd400;
  localparam logic [15:0] LongPressReset = 16'd2000;

  // Hat direction codes.
  localparam logic [1:0] HatCenter = 2'd0;
  localparam logic [1:0] HatForward = 2'd1;
  localparam logic [1:0] HatBackward = 2'd2;

  // Gesture event codes.
  localparam logic [2:0] GestNone = 3'd0;
  localparam logic [2:0] GestLong = 3'd4;

  // Held button bits.
  localparam logic [2:0] BitB1 = 3'b001;
  localparam logic [2:0] BitB2 = 3'b010;
  localparam logic [2:0] BitB3 = 3'b100;

  localparam logic [1:0] TapCountMax = 2'd3;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] pairing_hold_ticks;
    logic [15:0] tap_window_ticks;
    logic [15:0] long_press_ticks;
    logic        multipress_enable;
  } cfg_t;

  // Debounced view of one tick, passed to the gesture logic.
  typedef struct packed {
    logic [NumButtons-1:0] pressed;
    logic                  b3_press;
  } clean_t;

  typedef struct packed {
    logic [1:0]            hat_direction;
    logic [2:0]            held_buttons;
    logic                  report_needed;
    logic [2:0]            gesture_event;
    logic                  pairing_request;
    logic [NumButtons-1:0] clean_levels;
  } result_t;

endpackage

// ===== design/bdgq_if.sv =====
// Channel interfaces for tick input, result output and configuration writes.
interface bdgq_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] raw_levels;
  logic       link_up;
  modport source (output valid, raw_levels, link_up, input ready);
  modport sink (input valid, raw_levels, link_up, output ready);
endinterface

interface bdgq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] hat_direction;
  logic [2:0] held_buttons;
  logic       report_needed;
  logic [2:0] gesture_event;
  logic       pairing_request;
  logic [4:0] clean_levels;
  modport source (output valid, hat_direction, held_buttons, report_needed, gesture_event,
                  pairing_request, clean_levels, input ready);
  modport sink (input valid, hat_direction, held_buttons, report_needed, gesture_event,
                pairing_request, clean_levels, output ready);
endinterface

interface bdgq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/bdgq_debounce.sv =====
// Per-button stability counters that turn raw active-low levels into pressed flags.
module bdgq_debounce
  import bdgq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [NumButtons-1:0] raw_i,
  input  logic [7:0]            debounce_ticks_i,
  output clean_t                clean_o
);

  localparam logic [StableWidth-1:0] StableMax = '1;

  logic [NumButtons-1:0]  last_raw_q, last_raw_d;
  logic [NumButtons-1:0]  pressed_q, pressed_d;
  logic [StableWidth-1:0] count_q [NumButtons];
  logic [StableWidth-1:0] count_d [NumButtons];

  always_comb begin
    pressed_d = pressed_q;
    for (int i = 0; i < NumButtons; i++) begin
      if (raw_i[i] != last_raw_q[i]) begin
        count_d[i] = '0;
      end else if (count_q[i] != StableMax) begin
        count_d[i] = count_q[i] + StableWidth'(1);
      end else begin
        count_d[i] = count_q[i];
      end
      if (count_d[i] > {1'b0, debounce_ticks_i}) begin
        pressed_d[i] = ~raw_i[i];
      end
    end
    last_raw_d = raw_i;
  end

  assign clean_o.pressed  = pressed_d;
  assign clean_o.b3_press = pressed_d[IdxB3] & ~pressed_q[IdxB3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= '1;
      pressed_q  <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        count_q[i] <= '0;
      end
    end else if (step_i) begin
      last_raw_q <= last_raw_d;
      pressed_q  <= pressed_d;
      for (int i = 0; i < NumButtons; i++) begin
        count_q[i] <= count_d[i];
      end
    end
  end

endmodule

// ===== design/bdgq_gesture.sv =====
// Pairing hold, hat and held-button edge tracking, and tap and long-press classification.
module bdgq_gesture
  import bdgq_pkg::*;
#(
  parameter int unsigned TimerWidth = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    link_up_i,
  input  clean_t  clean_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam logic [TimerWidth-1:0] TimerMax = '1;

  logic [TimerWidth-1:0] hold_q, hold_d;
  logic [TimerWidth-1:0] tap_timer_q, tap_timer_d;
  logic                  pairing_done_q, pairing_done_d;
  logic [NumButtons-1:0] edge_held_q, edge_held_d;
  logic [1:0]            hat_q, hat_d;
  logic [2:0]            bits_q, bits_d;
  logic [1:0]            tap_count_q, tap_count_d;
  logic                  tap_was_pressed_q, tap_was_pressed_d;
  logic                  long_sent_q, long_sent_d;

  logic [NumButtons-1:0] p;
  logic                  report;
  logic                  pulse;
  logic [2:0]            gesture;

  assign p = clean_i.pressed;

  always_comb begin
    hold_d            = hold_q;
    pairing_done_d    = pairing_done_q;
    edge_held_d       = edge_held_q;
    hat_d             = hat_q;
    bits_d            = bits_q;
    tap_count_d       = tap_count_q;
    tap_was_pressed_d = tap_was_pressed_q;
    long_sent_d       = long_sent_q;
    report            = 1'b0;
    pulse             = 1'b0;
    gesture           = GestNone;

    tap_timer_d = (tap_timer_q == TimerMax) ? tap_timer_q : tap_timer_q + TimerWidth'(1);

    if (clean_i.b3_press) begin
      hold_d = '0;
    end else if (p[IdxB3] && hold_q != TimerMax) begin
      hold_d = hold_q + TimerWidth'(1);
    end

    if (p[IdxB3]) begin
      if (32'(hold_d) >= 32'(cfg_i.pairing_hold_ticks) && !pairing_done_q) begin
        pairing_done_d = 1'b1;
        pulse          = 1'b1;
      end
    end else begin
      pairing_done_d = 1'b0;
    end

    if (link_up_i) begin
      // The hat follows the latest press; a release centers it only when the
      // other direction is not pressed.
      if (p[IdxFwd] && !edge_held_d[IdxFwd]) begin
        hat_d               = HatForward;
        edge_held_d[IdxFwd] = 1'b1;
        report              = 1'b1;
      end else if (!p[IdxFwd] && edge_held_d[IdxFwd]) begin
        if (!p[IdxBwd]) begin
          hat_d = HatCenter;
        end
        edge_held_d[IdxFwd] = 1'b0;
        report              = 1'b1;
      end
      if (p[IdxBwd] && !edge_held_d[IdxBwd]) begin
        hat_d               = HatBackward;
        edge_held_d[IdxBwd] = 1'b1;
        report              = 1'b1;
      end else if (!p[IdxBwd] && edge_held_d[IdxBwd]) begin
        if (!p[IdxFwd]) begin
          hat_d = HatCenter;
        end
        edge_held_d[IdxBwd] = 1'b0;
        report              = 1'b1;
      end

      if (p[IdxB1] && !edge_held_d[IdxB1]) begin
        bits_d             = bits_d | BitB1;
        edge_held_d[IdxB1] = 1'b1;
        report             = 1'b1;
      end else if (!p[IdxB1] && edge_held_d[IdxB1]) begin
        bits_d             = bits_d & ~BitB1;
        edge_held_d[IdxB1] = 1'b0;
        report             = 1'b1;
      end
      if (p[IdxB2] && !edge_held_d[IdxB2]) begin
        bits_d             = bits_d | BitB2;
        edge_held_d[IdxB2] = 1'b1;
        report             = 1'b1;
      end else if (!p[IdxB2] && edge_held_d[IdxB2]) begin
        bits_d             = bits_d & ~BitB2;
        edge_held_d[IdxB2] = 1'b0;
        report             = 1'b1;
      end

      if (cfg_i.multipress_enable) begin
        if (p[IdxB3] && !tap_was_pressed_d && !pairing_done_d) begin
          tap_was_pressed_d = 1'b1;
          long_sent_d       = 1'b0;
          if (tap_count_d != TapCountMax) begin
            tap_count_d = tap_count_d + 2'd1;
          end
          tap_timer_d = '0;
        end else if (!p[IdxB3] && tap_was_pressed_d) begin
          tap_was_pressed_d = 1'b0;
        end
        if (p[IdxB3] && tap_was_pressed_d && !long_sent_d && !pairing_done_d &&
            32'(hold_d) >= 32'(cfg_i.long_press_ticks)) begin
          gesture     = GestLong;
          long_sent_d = 1'b1;
          tap_count_d = '0;
        end
        if (tap_count_d != 2'd0 && !tap_was_pressed_d && !long_sent_d &&
            32'(tap_timer_d) >= 32'(cfg_i.tap_window_ticks)) begin
          gesture     = {1'b0, tap_count_d};
          report      = 1'b1;
          tap_count_d = '0;
        end
      end else begin
        if (p[IdxB3] && !edge_held_d[IdxB3] && !pairing_done_d) begin
          bits_d             = bits_d | BitB3;
          edge_held_d[IdxB3] = 1'b1;
          report             = 1'b1;
        end else if (!p[IdxB3] && edge_held_d[IdxB3]) begin
          bits_d             = bits_d & ~BitB3;
          edge_held_d[IdxB3] = 1'b0;
          report             = 1'b1;
        end
      end
    end else begin
      bits_d = '0;
    end
  end

  assign result_o.hat_direction   = hat_d;
  assign result_o.held_buttons    = bits_d;
  assign result_o.report_needed   = report;
  assign result_o.gesture_event   = gesture;
  assign result_o.pairing_request = pulse;
  assign result_o.clean_levels    = p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q            <= '0;
      tap_timer_q       <= '0;
      pairing_done_q    <= 1'b0;
      edge_held_q       <= '0;
      hat_q             <= HatCenter;
      bits_q            <= '0;
      tap_count_q       <= '0;
      tap_was_pressed_q <= 1'b0;
      long_sent_q       <= 1'b0;
    end else if (step_i) begin
      hold_q            <= hold_d;
      tap_timer_q       <= tap_timer_d;
      pairing_done_q    <= pairing_done_d;
      edge_held_q       <= edge_held_d;
      hat_q             <= hat_d;
      bits_q            <= bits_d;
      tap_count_q       <= tap_count_d;
      tap_was_pressed_q <= tap_was_pressed_d;
      long_sent_q       <= long_sent_d;
    end
  end

endmodule

// ===== design/button_debounce_gesture_qualifier_core.sv =====
// Top level of the five-button debouncer and gesture qualifier with its result register.
//
// Usage: each transfer on in_i is one millisecond tick carrying the five raw
// active-low pin levels and the link-up flag. Every tick produces exactly one
// result on out_o: hat direction, held buttons, report flag, gesture event,
// pairing pulse and the debounced pressed flags.
// A tick accepted at a clock edge has its result registered and valid after
// that edge. Throughput is one tick per cycle while out_o.ready keeps up; the tick state is
// updated by combinational logic between the state registers and the result
// register, which is the only stage.
// in_i.ready is high while the result register is empty or being emptied in
// the same cycle, so a stalled receiver holds the result and stalls the
// input after one tick; nothing is dropped.
// Configuration writes on cfg_i are always taken; write them only while no
// tick is in flight. Reset loads the register defaults, releases all buttons,
// centers the hat and clears every timer. No clearing pass is needed.
module button_debounce_gesture_qualifier_core
  import bdgq_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bdgq_in_if.sink  in_i,
  bdgq_out_if.source out_o,
  bdgq_cfg_if.sink cfg_i
);

  cfg_t    cfg_q;
  clean_t  clean;
  result_t result_d, result_q;
  logic    out_valid_q;
  logic    step;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign step        = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= DebounceReset;
      cfg_q.pairing_hold_ticks <= PairingHoldReset;
      cfg_q.tap_window_ticks   <= TapWindowReset;
      cfg_q.long_press_ticks   <= LongPressReset;
      cfg_q.multipress_enable  <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegDebounce:    cfg_q.debounce_ticks     <= cfg_i.data[7:0];
        RegPairingHold: cfg_q.pairing_hold_ticks <= cfg_i.data;
        RegTapWindow:   cfg_q.tap_window_ticks   <= cfg_i.data;
        RegLongPress:   cfg_q.long_press_ticks   <= cfg_i.data;
        RegMultipress:  cfg_q.multipress_enable  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  bdgq_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .raw_i            (in_i.raw_levels),
    .debounce_ticks_i (cfg_q.debounce_ticks),
    .clean_o          (clean)
  );

  bdgq_gesture #(
    .TimerWidth (TIMER_WIDTH)
  ) u_gesture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .link_up_i (in_i.link_up),
    .clean_i   (clean),
    .cfg_i     (cfg_q),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.hat_direction   = result_q.hat_direction;
  assign out_o.held_buttons    = result_q.held_buttons;
  assign out_o.report_needed   = result_q.report_needed;
  assign out_o.gesture_event   = result_q.gesture_event;
  assign out_o.pairing_request = result_q.pairing_request;
  assign out_o.clean_levels    = result_q.clean_levels;

  // A tap event is always reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.gesture_event != GestNone &&
      out_o.gesture_event != GestLong |-> out_o.report_needed)
    else $error("tap event without report flag");

  // The pairing pulse only fires while button three is debounced as pressed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.pairing_request |-> out_o.clean_levels[IdxB3])
    else $error("pairing pulse without button three pressed");

  // Every accepted tick leaves a result waiting in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> out_o.valid)
    else $error("accepted tick produced no result");

  // Button three never becomes held while multi-press mode is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && cfg_q.multipress_enable && !result_q.held_buttons[2] && out_valid_q |=>
      !out_o.held_buttons[2])
    else $error("button three held in multi-press mode");

endmodule
